FILE: rtl/rmsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsc_pkg
// Shared types, constants and the round function of the reduced MORUS-style
// stream cipher.
// ----------------------------------------------------------------------------
package rmsc_pkg;

	localparam int WordW = 32;
	localparam int NumWords = 5;
	localparam int CfgIdxW = 2;
	localparam int InitRoundsDefault = 16;

	localparam logic [WordW-1:0] AllOnes = '1;

	localparam int Rot0 = 5;
	localparam int Rot1 = 31;
	localparam int Rot2 = 7;
	localparam int Rot3 = 22;
	localparam int Rot4 = 13;

	typedef logic [NumWords-1:0][WordW-1:0] words_t;

	typedef enum logic {
		OP_INIT    = 1'b0,
		OP_ENCRYPT = 1'b1
	} opcode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_IV      = 2'd0,
		REG_KEY     = 2'd1,
		REG_CONST_A = 2'd2,
		REG_CONST_B = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_INIT = 1'b1
	} state_t;

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned n);
		return (x << n) | (x >> (WordW - n));
	endfunction

	// Each word update sees the words already updated earlier in the same round.
	function automatic words_t cipher_round(input words_t w, input logic [WordW-1:0] m);
		words_t r;
		r = w;
		r[0] = rotl(r[0] ^ (r[1] & r[2]) ^ r[3], Rot0);
		r[1] = rotl(r[1] ^ m ^ (r[2] & r[3]) ^ r[4], Rot1);
		r[2] = rotl(r[2] ^ m ^ (r[3] & r[4]) ^ r[0], Rot2);
		r[3] = rotl(r[3] ^ m ^ (r[4] & r[0]) ^ r[1], Rot3);
		r[4] = rotl(r[4] ^ m ^ (r[0] ^ r[1]) ^ r[2], Rot4);
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/reduced_morus_stream_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reduced_morus_stream_cipher
// Five-word, 32-bit MORUS-style stream cipher with a single round unit.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) carries an opcode and a plaintext
// word. An initialize word loads the state from the configuration registers
// and then runs INIT_ROUNDS rounds, one per cycle, in the shared round unit;
// it produces no output word and keeps in_stall high until its last round
// is done. An encrypt word is finished in the cycle it is
// accepted: the ciphertext is registered and the state takes one round, so
// encrypt words stream at one per cycle while the output is not stalled.
// The output channel (out_valid/out_stall) is a single output register; while
// it holds a word the receiver stalls, in_stall stays high, and the
// ciphertext holds. The configuration channel (cfg_valid/cfg_ready) is always
// ready and writes one of four key/IV/constant registers by index.
// Reset clears the state words, the configuration registers and the output
// register; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module reduced_morus_stream_cipher #(
	parameter int INIT_ROUNDS = rmsc_pkg::InitRoundsDefault
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic                                opcode,
	input  wire logic [rmsc_pkg::WordW-1:0]          plaintext,
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic [rmsc_pkg::WordW-1:0]          ciphertext,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [rmsc_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire logic [rmsc_pkg::WordW-1:0]          cfg_data
);

	localparam int CntW = (INIT_ROUNDS > 1) ? $clog2(INIT_ROUNDS) : 1;
	localparam logic [CntW-1:0] LastRound = CntW'(INIT_ROUNDS - 1);

	rmsc_pkg::state_t state_q, state_d;
	rmsc_pkg::words_t words_q, round_out;

	logic [CntW-1:0]             rnd_cnt_q;
	logic [rmsc_pkg::WordW-1:0]  iv_q, key_q, const_a_q, const_b_q;
	logic [rmsc_pkg::WordW-1:0]  round_msg;
	logic                        out_valid_q;
	logic [rmsc_pkg::WordW-1:0]  ciphertext_q;
	logic                        cfg_take;
	logic                        load_init, enc_step, init_step;

	assign cfg_ready  = 1'b1;
	assign cfg_take   = cfg_valid && cfg_ready;
	assign out_valid  = out_valid_q;
	assign ciphertext = ciphertext_q;

	// The round unit is shared by encrypt words and initialization rounds.
	assign round_msg = (state_q == rmsc_pkg::ST_INIT) ? '0 : plaintext;
	assign round_out = rmsc_pkg::cipher_round(words_q, round_msg);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		load_init = 1'b0;
		enc_step  = 1'b0;
		init_step = 1'b0;
		unique case (state_q)
			rmsc_pkg::ST_IDLE: begin
				in_stall = out_valid_q && out_stall;
				if (in_valid && !in_stall) begin
					if (opcode == rmsc_pkg::OP_ENCRYPT) begin
						enc_step = 1'b1;
					end else begin
						load_init = 1'b1;
						state_d   = rmsc_pkg::ST_INIT;
					end
				end
			end
			rmsc_pkg::ST_INIT: begin
				init_step = 1'b1;
				if (rnd_cnt_q == LastRound) begin
					state_d = rmsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmsc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_cnt_q <= '0;
		end else if (load_init) begin
			rnd_cnt_q <= '0;
		end else if (init_step) begin
			rnd_cnt_q <= rnd_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
		end else if (load_init) begin
			words_q[0] <= iv_q;
			words_q[1] <= key_q;
			words_q[2] <= rmsc_pkg::AllOnes;
			words_q[3] <= const_a_q;
			words_q[4] <= const_b_q;
		end else if (enc_step || init_step) begin
			words_q <= round_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q      <= '0;
			key_q     <= '0;
			const_a_q <= '0;
			const_b_q <= '0;
		end else if (cfg_take) begin
			unique case (rmsc_pkg::cfg_reg_t'(cfg_index))
				rmsc_pkg::REG_IV:      iv_q      <= cfg_data;
				rmsc_pkg::REG_KEY:     key_q     <= cfg_data;
				rmsc_pkg::REG_CONST_A: const_a_q <= cfg_data;
				rmsc_pkg::REG_CONST_B: const_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (enc_step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The keystream comes from the state before this word's round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciphertext_q <= '0;
		end else if (enc_step) begin
			ciphertext_q <= plaintext ^ words_q[0] ^ words_q[1] ^ (words_q[2] & words_q[3]);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rmsc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsc_checker
// Port-level checks of the stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
module rmsc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        opcode,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [rmsc_pkg::WordW-1:0]  ciphertext
);

	logic take_enc, take_init;
	assign take_enc  = in_valid && !in_stall && (opcode == rmsc_pkg::OP_ENCRYPT);
	assign take_init = in_valid && !in_stall && (opcode == rmsc_pkg::OP_INIT);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ciphertext))
		else $error("output word changed or dropped while stalled");

	// Every accepted encrypt word shows a ciphertext in the next cycle.
	a_enc_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_enc |=> out_valid)
		else $error("encrypt word gave no ciphertext");

	// An initialize word gives no output word.
	a_init_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take_init |=> !out_valid)
		else $error("initialize word produced an output word");

	// The first initialization round keeps the input stalled.
	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take_init |=> in_stall)
		else $error("input not stalled during initialization");

endmodule

bind reduced_morus_stream_cipher rmsc_checker u_rmsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.opcode     (opcode),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.ciphertext (ciphertext)
);
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reduced MORUS-style stream cipher. A scoreboard
// keeps its own copy of the five state words and the key setup, predicts the
// ciphertext of every accepted encrypt word and compares it with what the
// block returns. Directed words come first, then random phases with varied
// key setups, random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int InitRounds = rmsc_pkg::InitRoundsDefault;
	localparam int SettleCycles = InitRounds + 4;
	localparam int IdleLimit = 3000;

	class keystream_scoreboard;
		logic [rmsc_pkg::WordW-1:0] key_setup [4];
		logic [rmsc_pkg::WordW-1:0] st [rmsc_pkg::NumWords];
		logic [rmsc_pkg::WordW-1:0] expected_ct [$];
		int errors;

		function new();
			foreach (key_setup[i]) key_setup[i] = '0;
			foreach (st[i]) st[i] = '0;
			errors = 0;
		endfunction

		function void set_reg(rmsc_pkg::cfg_reg_t idx, logic [rmsc_pkg::WordW-1:0] d);
			key_setup[idx] = d;
		endfunction

		function logic [rmsc_pkg::WordW-1:0] rol(logic [rmsc_pkg::WordW-1:0] x, int n);
			return (x << n) | (x >> (rmsc_pkg::WordW - n));
		endfunction

		// Words are updated in order, so later terms use the fresh values.
		function void advance_state(logic [rmsc_pkg::WordW-1:0] m);
			st[0] = rol(st[0] ^ (st[1] & st[2]) ^ st[3], 5);
			st[1] = rol(st[1] ^ m ^ (st[2] & st[3]) ^ st[4], 31);
			st[2] = rol(st[2] ^ m ^ (st[3] & st[4]) ^ st[0], 7);
			st[3] = rol(st[3] ^ m ^ (st[4] & st[0]) ^ st[1], 22);
			st[4] = rol(st[4] ^ m ^ (st[0] ^ st[1]) ^ st[2], 13);
		endfunction

		function void note_input(rmsc_pkg::opcode_t op, logic [rmsc_pkg::WordW-1:0] pt);
			if (op == rmsc_pkg::OP_INIT) begin
				st[0] = key_setup[rmsc_pkg::REG_IV];
				st[1] = key_setup[rmsc_pkg::REG_KEY];
				st[2] = '1;
				st[3] = key_setup[rmsc_pkg::REG_CONST_A];
				st[4] = key_setup[rmsc_pkg::REG_CONST_B];
				for (int r = 0; r < InitRounds; r++)
					advance_state('0);
			end else begin
				expected_ct.push_back(pt ^ st[0] ^ st[1] ^ (st[2] & st[3]));
				advance_state(pt);
			end
		endfunction

		task report(input string msg);
			$display("%0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_result(input logic [rmsc_pkg::WordW-1:0] ct);
			logic [rmsc_pkg::WordW-1:0] want;
			if (expected_ct.size() == 0) begin
				report($sformatf("unexpected ciphertext %h", ct));
			end else begin
				want = expected_ct.pop_front();
				if (ct !== want)
					report($sformatf("ciphertext mismatch: got %h want %h", ct, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	rmsc_pkg::opcode_t opcode;
	logic [rmsc_pkg::WordW-1:0] plaintext;
	logic out_valid;
	logic out_stall;
	logic [rmsc_pkg::WordW-1:0] ciphertext;
	logic cfg_valid;
	logic cfg_ready;
	rmsc_pkg::cfg_reg_t cfg_index;
	logic [rmsc_pkg::WordW-1:0] cfg_data;

	keystream_scoreboard sb;
	bit quiet;
	bit hold_req;
	int burst_left;
	int idle_cycles;

	reduced_morus_stream_cipher #(
		.INIT_ROUNDS(InitRounds)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.plaintext(plaintext),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ciphertext(ciphertext),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [rmsc_pkg::WordW-1:0] pick_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Output side: stall bursts of random length, or a long hold when asked.
	initial begin
		int stall_left;
		bit hold_taken;
		out_stall = 1'b0;
		stall_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = 120;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				stall_left = quiet ? 0 : pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(ciphertext);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Leaves in_valid high after the accepting edge; at the following falling
	// edge drain_results lowers it, and so does the next call when it waits a gap.
	task automatic send_word(input rmsc_pkg::opcode_t op, input logic [rmsc_pkg::WordW-1:0] pt);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = quiet ? 0 : pick_gap();
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		plaintext = pt;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_input(op, pt);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_ct.size() != 0)
			@(posedge clk);
	endtask

	// An initialize word gives no result, so wait out its rounds as well.
	task automatic settle();
		drain_results();
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input rmsc_pkg::cfg_reg_t idx,
			input logic [rmsc_pkg::WordW-1:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		sb.set_reg(idx, d);
	endtask

	task automatic load_setup(input logic [rmsc_pkg::WordW-1:0] iv,
			input logic [rmsc_pkg::WordW-1:0] key,
			input logic [rmsc_pkg::WordW-1:0] ca, input logic [rmsc_pkg::WordW-1:0] cb);
		write_reg(rmsc_pkg::REG_IV, iv);
		write_reg(rmsc_pkg::REG_KEY, key);
		write_reg(rmsc_pkg::REG_CONST_A, ca);
		write_reg(rmsc_pkg::REG_CONST_B, cb);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		rmsc_pkg::opcode_t op;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = rmsc_pkg::OP_INIT;
		plaintext = '0;
		cfg_valid = 1'b0;
		cfg_index = rmsc_pkg::REG_IV;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Encrypt straight out of reset runs on the all-zero state.
		send_word(rmsc_pkg::OP_ENCRYPT, 32'h0000_0000);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'hffff_ffff);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'ha5a5_a5a5);
		send_word(rmsc_pkg::OP_INIT, 32'hffff_ffff);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'h0000_0000);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'hffff_ffff);
		settle();

		load_setup('1, '1, '1, '1);
		send_word(rmsc_pkg::OP_INIT, 32'h0000_0000);
		send_word(rmsc_pkg::OP_INIT, 32'h1234_5678);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'hffff_ffff);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'h0000_0000);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'h5a5a_5a5a);
		send_word(rmsc_pkg::OP_INIT, 32'h0000_0000);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'h8000_0001);
		settle();

		load_setup('0, '0, '0, '0);
		send_word(rmsc_pkg::OP_INIT, 32'h0000_0000);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'h0000_0000);
		send_word(rmsc_pkg::OP_ENCRYPT, 32'hffff_ffff);
		settle();

		load_setup(32'h0123_4567, 32'h89ab_cdef, 32'hdb3d_1876, 32'h3a2c_9f15);
		send_word(rmsc_pkg::OP_INIT, 32'h0000_0000);
		for (int n = 0; n < 6; n++)
			send_word(rmsc_pkg::OP_ENCRYPT, $urandom);

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			load_setup(pick_word(), pick_word(), pick_word(), pick_word());
			quiet = (ph % 4 == 1);
			if (ph == 3) begin
				hold_req = 1'b1;
				burst_left = 40;
			end
			if ($urandom_range(0, 4) != 0)
				send_word(rmsc_pkg::OP_INIT, $urandom);
			for (int n = 0; n < 170; n++) begin
				if (n == 85)
					drain_results();
				op = ($urandom_range(0, 99) < 8) ? rmsc_pkg::OP_INIT : rmsc_pkg::OP_ENCRYPT;
				send_word(op, $urandom);
			end
		end
		quiet = 1'b0;
		settle();

		if (sb.expected_ct.size() != 0)
			sb.report($sformatf("%0d ciphertext words never arrived", sb.expected_ct.size()));
		if (sb.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
